/* rtl/alir_pkg.sv */
// Shared constants, codes and types for the array list insert/remove core.
`default_nettype none
package alir_pkg;

    localparam int DEPTH       = 512;
    localparam int ADDR_WIDTH  = $clog2(DEPTH);
    localparam int CNT_WIDTH   = $clog2(DEPTH + 1);
    localparam int WORD_WIDTH  = 32;
    localparam int POS_WIDTH   = 9;
    localparam int CMD_WIDTH   = 3;
    localparam int STAT_WIDTH  = 2;

    localparam logic [CMD_WIDTH-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_INS_END   = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_INS_AT    = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_RM_FRONT  = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_RM_END    = 3'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_RM_AT     = 3'd5;
    localparam logic [CMD_WIDTH-1:0] CMD_READ_AT   = 3'd6;

    localparam logic [STAT_WIDTH-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_WIDTH-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_WIDTH-1:0] STAT_BAD  = 2'd2;

    typedef struct packed {
        logic                  we;
        logic [ADDR_WIDTH-1:0] waddr;
        logic [WORD_WIDTH-1:0] wdata;
        logic [ADDR_WIDTH-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [STAT_WIDTH-1:0] status;
        logic                  value_valid;
        logic [WORD_WIDTH-1:0] returned_value;
        logic [CNT_WIDTH-1:0]  entry_count;
    } result_t;

endpackage
`default_nettype wire

/* rtl/alir_ram.sv */
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module alir_ram (
    input  wire logic                               aclk,
    input  wire alir_pkg::mem_req_t                 req,
    output logic [alir_pkg::WORD_WIDTH-1:0]         rdata
);
    import alir_pkg::*;

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/alir_ctrl.sv */
// Sequencer: decodes one operation and walks the store to open or close a gap.
`default_nettype none
module alir_ctrl (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [alir_pkg::CMD_WIDTH-1:0]     cmd,
    input  wire logic [alir_pkg::POS_WIDTH-1:0]     position,
    input  wire logic [alir_pkg::WORD_WIDTH-1:0]    entry_value,
    input  wire logic                               out_free,
    input  wire logic [alir_pkg::WORD_WIDTH-1:0]    rdata,
    output alir_pkg::mem_req_t                      req,
    output logic                                    idle,
    output logic                                    res_valid,
    output alir_pkg::result_t                       res
);
    import alir_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SHUP      = 3'd1;
    localparam logic [2:0] ST_SHUP_TAIL = 3'd2;
    localparam logic [2:0] ST_PUT       = 3'd3;
    localparam logic [2:0] ST_CAP       = 3'd4;
    localparam logic [2:0] ST_SHDN      = 3'd5;
    localparam logic [2:0] ST_SHDN_TAIL = 3'd6;
    localparam logic [2:0] ST_FIN       = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic [ADDR_WIDTH-1:0] wptr_reg, wptr_next;
    logic [ADDR_WIDTH-1:0] at_reg, at_next;
    logic [WORD_WIDTH-1:0] word_reg, word_next;
    logic [WORD_WIDTH-1:0] ret_reg, ret_next;
    logic [STAT_WIDTH-1:0] status_reg, status_next;
    logic                  vflag_reg, vflag_next;
    logic                  pend_reg, pend_next;
    logic                  remove_reg, remove_next;
    logic                  shift_reg, shift_next;

    logic [CNT_WIDTH-1:0]  pos_ext;
    logic [CNT_WIDTH-1:0]  cnt_m1;
    logic [ADDR_WIDTH-1:0] last_addr;
    logic [CNT_WIDTH-1:0]  ins_at;
    logic [CNT_WIDTH-1:0]  rm_at;

    assign pos_ext   = CNT_WIDTH'(position);
    assign cnt_m1    = cnt_reg - 1'b1;
    assign last_addr = cnt_m1[ADDR_WIDTH-1:0];
    assign ins_at    = (cmd == CMD_INS_FRONT) ? '0 :
                       (cmd == CMD_INS_END)   ? cnt_reg : pos_ext;
    assign rm_at     = (cmd == CMD_RM_FRONT)  ? '0 :
                       (cmd == CMD_RM_END)    ? cnt_m1 : pos_ext;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        addr_next   = addr_reg;
        wptr_next   = wptr_reg;
        at_next     = at_reg;
        word_next   = word_reg;
        ret_next    = ret_reg;
        status_next = status_reg;
        vflag_next  = vflag_reg;
        pend_next   = pend_reg;
        remove_next = remove_reg;
        shift_next  = shift_reg;
        req.we      = 1'b0;
        req.waddr   = wptr_reg;
        req.wdata   = rdata;
        req.raddr   = addr_reg;
        res_valid   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    status_next = STAT_OK;
                    vflag_next  = 1'b0;
                    ret_next    = '0;
                    word_next   = entry_value;
                    pend_next   = 1'b0;
                    state_next  = ST_FIN;
                    unique case (cmd) inside
                        CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
                            if (cnt_reg == CNT_WIDTH'(DEPTH)) begin
                                status_next = STAT_FULL;
                            end else if (ins_at > cnt_reg) begin
                                status_next = STAT_BAD;
                            end else if (ins_at == cnt_reg) begin
                                req.we    = 1'b1;
                                req.waddr = ins_at[ADDR_WIDTH-1:0];
                                req.wdata = entry_value;
                                cnt_next  = cnt_reg + 1'b1;
                            end else begin
                                addr_next  = last_addr;
                                wptr_next  = cnt_reg[ADDR_WIDTH-1:0];
                                at_next    = ins_at[ADDR_WIDTH-1:0];
                                state_next = ST_SHUP;
                            end
                        end
                        CMD_RM_FRONT, CMD_RM_END, CMD_RM_AT, CMD_READ_AT: begin
                            if (cnt_reg == '0 || rm_at >= cnt_reg) begin
                                status_next = STAT_BAD;
                            end else begin
                                req.raddr   = rm_at[ADDR_WIDTH-1:0];
                                addr_next   = rm_at[ADDR_WIDTH-1:0] + 1'b1;
                                wptr_next   = rm_at[ADDR_WIDTH-1:0];
                                remove_next = (cmd != CMD_READ_AT);
                                shift_next  = (cmd != CMD_READ_AT) && (rm_at != cnt_m1);
                                state_next  = ST_CAP;
                            end
                        end
                        default: begin
                            status_next = STAT_BAD;
                        end
                    endcase
                end
            end
            ST_SHUP: begin
                if (pend_reg) begin
                    req.we    = 1'b1;
                    wptr_next = wptr_reg - 1'b1;
                end
                pend_next = 1'b1;
                if (addr_reg == at_reg) begin
                    state_next = ST_SHUP_TAIL;
                end else begin
                    addr_next = addr_reg - 1'b1;
                end
            end
            ST_SHUP_TAIL: begin
                req.we     = 1'b1;
                wptr_next  = wptr_reg - 1'b1;
                state_next = ST_PUT;
            end
            ST_PUT: begin
                req.we     = 1'b1;
                req.wdata  = word_reg;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_FIN;
            end
            ST_CAP: begin
                ret_next   = rdata;
                vflag_next = 1'b1;
                if (!shift_reg) begin
                    if (remove_reg) begin
                        cnt_next = cnt_m1;
                    end
                    state_next = ST_FIN;
                end else if (addr_reg == last_addr) begin
                    state_next = ST_SHDN_TAIL;
                end else begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = ST_SHDN;
                end
            end
            ST_SHDN: begin
                req.we    = 1'b1;
                wptr_next = wptr_reg + 1'b1;
                if (addr_reg == last_addr) begin
                    state_next = ST_SHDN_TAIL;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_SHDN_TAIL: begin
                req.we     = 1'b1;
                cnt_next   = cnt_m1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        wptr_reg   <= wptr_next;
        at_reg     <= at_next;
        word_reg   <= word_next;
        ret_reg    <= ret_next;
        status_reg <= status_next;
        vflag_reg  <= vflag_next;
        pend_reg   <= pend_next;
        remove_reg <= remove_next;
        shift_reg  <= shift_next;
    end

    assign idle                = (state_reg == ST_IDLE);
    assign res.status          = status_reg;
    assign res.value_valid     = vflag_reg;
    assign res.returned_value  = ret_reg;
    assign res.entry_count     = cnt_reg;

endmodule
`default_nettype wire

/* rtl/array_list_insert_remove_core.sv */
// Top level of the array list core: stream ports, entry store, sequencer, result register.
//
// Usage: each beat on the s_ channel is one list operation (insert front/end/at,
// remove front/end/at, read at). Every operation returns exactly one beat on
// the m_ channel carrying status, the removed or read word and the new count.
// With the result register free, a reject or an append goes from idle straight
// to the finish state; a read, or a remove with nothing above it, first passes
// the capture state. An insert at p with n entries (p < n) moves entries p..n-1
// up, then writes the new word; a remove at p moves the entries above it down.
// Shifting moves one word per cycle through the single-read, single-write entry
// store, so the worst case is an insert at the front of 511 entries.
// One operation is in flight at a time: s_tready is high only while the
// sequencer is idle, so the next beat is taken at the earliest in the cycle
// after the previous result is handed to the result register.
// The result register holds a finished beat while the receiver stalls; the
// next operation may be accepted and worked on meanwhile, and its result waits
// in the sequencer, with s_tready low, until the register frees up.
// Reset (aresetn low, synchronous) empties the list and drops any pending beat.
`default_nettype none
module array_list_insert_remove_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // position[8:0], entry_value[40:9], zero pad
    input  wire logic [2:0]  s_tuser,   // cmd[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // returned_value[31:0], entry_count[41:32], zero pad
    output logic [2:0]       m_tuser    // status[1:0], value_valid[2]
);
    import alir_pkg::*;

    mem_req_t              req;
    logic [WORD_WIDTH-1:0] rdata;
    logic                  idle;
    logic                  res_valid;
    result_t               res;
    logic                  out_free;
    logic                  m_valid_reg;
    result_t               m_res_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = idle;

    alir_ram u_ram (
        .aclk  (aclk),
        .req   (req),
        .rdata (rdata)
    );

    alir_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_tvalid && idle),
        .cmd         (s_tuser[CMD_WIDTH-1:0]),
        .position    (s_tdata[POS_WIDTH-1:0]),
        .entry_value (s_tdata[POS_WIDTH +: WORD_WIDTH]),
        .out_free    (out_free),
        .rdata       (rdata),
        .req         (req),
        .idle        (idle),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_res_reg.entry_count, m_res_reg.returned_value};
    assign m_tuser  = {m_res_reg.value_valid, m_res_reg.status};

endmodule
`default_nettype wire

/* dv/alir_list_checker.sv */
// Checker for the array list core: mirrors the list, predicts each result beat and compares.
module alir_list_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    input  wire logic [2:0]  m_tuser,
    output int               error_count,
    output int               pending,
    output int               list_size
);
    timeunit 1ns;
    timeprecision 1ps;
    import alir_pkg::*;

    logic [WORD_WIDTH-1:0] shadow_list[$];
    result_t               expected_results[$];
    int                    n_errors = 0;

    function automatic result_t apply_list_op(input logic [CMD_WIDTH-1:0] op,
                                              input logic [POS_WIDTH-1:0] pos,
                                              input logic [WORD_WIDTH-1:0] word);
        result_t r;
        int      at;
        int      n;
        r        = '0;
        r.status = STAT_OK;
        n        = shadow_list.size();
        case (op)
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
                at = (op == CMD_INS_FRONT) ? 0 : (op == CMD_INS_END) ? n : int'(pos);
                if (n >= DEPTH) begin
                    r.status = STAT_FULL;
                end else if (at > n) begin
                    r.status = STAT_BAD;
                end else begin
                    shadow_list.insert(at, word);
                end
            end
            CMD_RM_FRONT, CMD_RM_END, CMD_RM_AT, CMD_READ_AT: begin
                at = (op == CMD_RM_FRONT) ? 0 : (op == CMD_RM_END) ? n - 1 : int'(pos);
                if (n == 0 || at >= n) begin
                    r.status = STAT_BAD;
                end else begin
                    r.value_valid    = 1'b1;
                    r.returned_value = shadow_list[at];
                    if (op != CMD_READ_AT) begin
                        shadow_list.delete(at);
                    end
                end
            end
            default: begin
                r.status = STAT_BAD;
            end
        endcase
        r.entry_count = CNT_WIDTH'(shadow_list.size());
        return r;
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            // result first: a result beat always belongs to an earlier operation
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat: expected none, %s %0h tdata %0h",
                             $time, "actual tuser", m_tuser, m_tdata);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    cmp_field("status", 32'(want.status), 32'(m_tuser[1:0]));
                    cmp_field("value_valid", 32'(want.value_valid), 32'(m_tuser[2]));
                    cmp_field("returned_value", want.returned_value, m_tdata[31:0]);
                    cmp_field("entry_count", 32'(want.entry_count), 32'(m_tdata[41:32]));
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_list_op(s_tuser, s_tdata[8:0], s_tdata[40:9]));
            end
        end
        error_count <= n_errors;
        pending     <= expected_results.size();
        list_size   <= shadow_list.size();
    end

endmodule

/* dv/array_list_insert_remove_core_tb.sv */
// Testbench top for the array list core: clock, reset, operation stimulus, idling and verdict.
module array_list_insert_remove_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import alir_pkg::*;

    localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 3'd7;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    int   error_count;
    int   pending;
    int   list_size;

    int   snd_idle_pct  = 0;
    int   rcv_stall_pct = 0;
    logic hold_req      = 1'b0;
    logic hold_ack      = 1'b0;
    int   hold_left     = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    array_list_insert_remove_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    alir_list_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .error_count (error_count),
        .pending     (pending),
        .list_size   (list_size)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    task automatic send_op(input logic [CMD_WIDTH-1:0] op, input logic [POS_WIDTH-1:0] pos,
                           input logic [WORD_WIDTH-1:0] word);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, word, pos};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // random operations steered toward a target fill level
    task automatic run_mix(input int snd_pct, input int rcv_pct, input int target, input int n_ops);
        int                    cnt;
        int                    r;
        int                    kind;
        int                    ins_pct;
        logic [CMD_WIDTH-1:0]  op;
        logic [POS_WIDTH-1:0]  pos;
        logic [WORD_WIDTH-1:0] word;
        snd_idle_pct = snd_pct;
        rcv_stall_pct <= rcv_pct;
        for (int i = 0; i < n_ops; i++) begin
            cnt     = list_size;
            ins_pct = (cnt < target) ? 92 : (cnt > target) ? 8 : 50;
            word    = $urandom;
            r       = $urandom_range(0, 9);
            if (r == 0) word = '0;
            if (r == 1) word = '1;
            pos  = POS_WIDTH'($urandom);
            kind = $urandom_range(0, 99);
            r    = $urandom_range(0, 99);
            if (r < 4) begin
                op = (r < 2) ? CMD_UNUSED : CMD_WIDTH'($urandom_range(0, 6));
            end else if ($urandom_range(0, 99) < ins_pct) begin
                op = (kind < 55) ? CMD_INS_END : (kind < 70) ? CMD_INS_FRONT : CMD_INS_AT;
                if (op == CMD_INS_AT) begin
                    if ($urandom_range(0, 9) != 0 || cnt >= 511) begin
                        pos = (cnt > 511) ? 9'd511 : POS_WIDTH'($urandom_range(0, cnt));
                    end else begin
                        pos = POS_WIDTH'($urandom_range(cnt + 1, 511));
                    end
                end
            end else begin
                op = (kind < 25) ? CMD_RM_FRONT : (kind < 50) ? CMD_RM_END :
                     (kind < 75) ? CMD_RM_AT : CMD_READ_AT;
                if (op == CMD_RM_AT || op == CMD_READ_AT) begin
                    if ($urandom_range(0, 9) != 0 && cnt > 0) begin
                        pos = POS_WIDTH'($urandom_range(0, cnt - 1));
                    end else begin
                        pos = (cnt > 511) ? 9'd511 : POS_WIDTH'($urandom_range(cnt, 511));
                    end
                end
            end
            send_op(op, pos, word);
        end
    endtask

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty list, bounds, each command, extreme words
        send_op(CMD_RM_FRONT, 9'd0, 32'h0);
        send_op(CMD_RM_END, 9'd0, 32'h0);
        send_op(CMD_RM_AT, 9'd0, 32'h0);
        send_op(CMD_READ_AT, 9'd0, 32'h0);
        send_op(CMD_INS_AT, 9'd1, 32'hDEAD_BEEF);
        send_op(CMD_INS_FRONT, 9'd0, 32'h0000_0000);
        send_op(CMD_INS_END, 9'd0, 32'hFFFF_FFFF);
        send_op(CMD_INS_AT, 9'd2, 32'hA5A5_5A5A);
        send_op(CMD_INS_AT, 9'd1, 32'h1234_5678);
        send_op(CMD_INS_AT, 9'd511, 32'hFFFF_FFFF);
        send_op(CMD_READ_AT, 9'd0, 32'hFFFF_FFFF);
        send_op(CMD_READ_AT, 9'd3, 32'h0);
        send_op(CMD_READ_AT, 9'd4, 32'h0);
        send_op(CMD_READ_AT, 9'd511, 32'h0);
        send_op(CMD_UNUSED, 9'd511, 32'hFFFF_FFFF);
        send_op(CMD_RM_AT, 9'd1, 32'h0);
        send_op(CMD_RM_FRONT, 9'd0, 32'h0);
        send_op(CMD_RM_AT, 9'd5, 32'h0);
        send_op(CMD_RM_END, 9'd0, 32'h0);
        send_op(CMD_RM_AT, 9'd0, 32'h0);
        send_op(CMD_RM_END, 9'd0, 32'h0);

        run_mix(0, 0, 6, 80);
        run_mix(81, 0, 24, 80);

        // receiver holds off while beats keep coming, then sender waits for all results
        snd_idle_pct = 0;
        rcv_stall_pct <= 0;
        hold_req <= ~hold_req;
        for (int i = 0; i < 12; i++) begin
            send_op(CMD_INS_END, POS_WIDTH'($urandom), $urandom);
        end
        wait_drained();

        run_mix(0, 81, 512, 600);
        run_mix(18, 18, 512, 100);
        run_mix(81, 0, 0, 280);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
